// ===== sv/tsa_pkg.sv =====
`default_nettype none
package tsa_pkg;

	localparam int unsigned SLOT_COUNT_DEF = 14;

	localparam int unsigned CH_W   = 4;
	localparam int unsigned QCH_W  = 5;
	localparam int unsigned PORT_W = 3;
	localparam int unsigned VAL_W  = 8;
	localparam int unsigned TAG_W  = 32;

	typedef enum logic [1:0] {
		ACT_START   = 2'd0,
		ACT_STOP    = 2'd1,
		ACT_STOPALL = 2'd2,
		ACT_QUERY   = 2'd3
	} tsa_action_t;

	localparam logic [PORT_W-1:0] PORT_KEY = 3'd0;
	localparam logic [PORT_W-1:0] PORT_A   = 3'd3;
	localparam logic [PORT_W-1:0] PORT_B   = 3'd7;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic decide;
		logic next_beat;
		logic scan;
	} tsa_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic scan_start;
		logic is_start;
		logic out_last;
		logic scan_hit;
	} tsa_sts_t;

endpackage
`default_nettype wire

// ===== sv/tagged_slot_allocator.sv =====
// Slot allocator with a table of SLOT_COUNT tagged slots (channel = slot index).
// Commands: start (reuse the matching slot or take the lowest free one, then
// send three port writes), stop (free the matching slot, one write), stop-all
// (free every active slot, one write each, in index order) and query (report
// the matching channel or -1). Every request ends with a result that has
// last set; a request with no write returns one result with write_valid low.
// One request is handled at a time: in_ready is high only while nothing is
// pending, and it returns in the cycle after the final result is taken. The
// tag compare runs against all slots in parallel on acceptance; for start,
// stop, query and an empty stop-all the first result is registered in the
// decision cycle, and each further result of a start follows in the cycle
// after the previous one is taken. Stop-all with active slots walks the table
// one slot per cycle after its decision cycle, pausing at each active slot
// until its result is taken; each active slot gives one result and free slots
// are skipped on the way.
`default_nettype none
module tagged_slot_allocator #(
	parameter int unsigned SLOT_COUNT = tsa_pkg::SLOT_COUNT_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [1:0]                        action,
	input  wire logic [tsa_pkg::TAG_W-1:0]         tag,
	input  wire logic signed [tsa_pkg::VAL_W-1:0]  param_a,
	input  wire logic signed [tsa_pkg::VAL_W-1:0]  param_b,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic                                   write_valid,
	output logic [tsa_pkg::CH_W-1:0]               channel,
	output logic [tsa_pkg::PORT_W-1:0]             port_index,
	output logic signed [tsa_pkg::VAL_W-1:0]       write_value,
	output logic signed [tsa_pkg::QCH_W-1:0]       query_channel,
	output logic                                   last
);
	import tsa_pkg::*;

	tsa_cmd_t cmd;
	tsa_sts_t sts;

	tsa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	tsa_datapath #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.action        (action),
		.tag           (tag),
		.param_a       (param_a),
		.param_b       (param_b),
		.write_valid   (write_valid),
		.channel       (channel),
		.port_index    (port_index),
		.write_value   (write_value),
		.query_channel (query_channel),
		.last          (last)
	);

endmodule
`default_nettype wire

// ===== sv/tsa_ctrl.sv =====
`default_nettype none
module tsa_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  wire logic             out_ready,
	input  wire tsa_pkg::tsa_sts_t sts,
	output tsa_pkg::tsa_cmd_t     cmd
);
	import tsa_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_DECIDE = 4'b0010,
		ST_SEND   = 4'b0100,
		ST_SCAN   = 4'b1000
	} state_t;

	state_t state_q, state_d;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_SEND);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (sts.scan_start) begin
					state_d = ST_SCAN;
				end else begin
					cmd.decide = 1'b1;
					state_d    = ST_SEND;
				end
			end
			ST_SEND: begin
				if (out_ready) begin
					if (sts.out_last) begin
						state_d = ST_IDLE;
					end else if (sts.is_start) begin
						cmd.next_beat = 1'b1;
					end else begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_hit) begin
					state_d = ST_SEND;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

// ===== sv/tsa_datapath.sv =====
`default_nettype none
module tsa_datapath #(
	parameter int unsigned SLOT_COUNT = tsa_pkg::SLOT_COUNT_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire tsa_pkg::tsa_cmd_t                 cmd,
	output tsa_pkg::tsa_sts_t                      sts,
	input  wire logic [1:0]                        action,
	input  wire logic [tsa_pkg::TAG_W-1:0]         tag,
	input  wire logic signed [tsa_pkg::VAL_W-1:0]  param_a,
	input  wire logic signed [tsa_pkg::VAL_W-1:0]  param_b,
	output logic                                   write_valid,
	output logic [tsa_pkg::CH_W-1:0]               channel,
	output logic [tsa_pkg::PORT_W-1:0]             port_index,
	output logic signed [tsa_pkg::VAL_W-1:0]       write_value,
	output logic signed [tsa_pkg::QCH_W-1:0]       query_channel,
	output logic                                   last
);
	import tsa_pkg::*;

	localparam int unsigned IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	// Slot table
	logic [SLOT_COUNT-1:0] active_q;
	logic [TAG_W-1:0]      slot_tag_q [SLOT_COUNT];

	// Captured request
	tsa_action_t             act_q;
	logic [TAG_W-1:0]        tag_q;
	logic signed [VAL_W-1:0] pa_q, pb_q;
	logic [SLOT_COUNT-1:0]   match_s1;

	logic [IW-1:0] scan_idx_q;
	logic          beat_q;

	// Result register
	logic                    wv_q, last_q;
	logic [CH_W-1:0]         ch_q;
	logic [PORT_W-1:0]       port_q;
	logic signed [VAL_W-1:0] val_q;
	logic signed [QCH_W-1:0] qch_q;

	logic [SLOT_COUNT-1:0] match_d, rest_vec;
	logic [IW-1:0]         match_idx, free_idx, sel_idx;
	logic                  match_any, free_any, start_ok;
	logic [QCH_W-1:0]      match_idx5, sel_idx5, scan_idx5;

	// First result of a request, as chosen in the decision cycle.
	logic                    dec_wv, dec_last;
	logic [CH_W-1:0]         dec_ch;
	logic signed [VAL_W-1:0] dec_val;
	logic signed [QCH_W-1:0] dec_qch;

	always_comb begin
		for (int i = 0; i < SLOT_COUNT; i++) begin
			match_d[i]  = active_q[i] && (slot_tag_q[i] == tag);
			rest_vec[i] = active_q[i] && (IW'(i) > scan_idx_q);
		end
	end

	// Lowest set bit wins: scan from the top down so the last hit is the lowest.
	always_comb begin
		match_idx = '0;
		free_idx  = '0;
		for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
			if (match_s1[i]) begin
				match_idx = IW'(i);
			end
			if (!active_q[i]) begin
				free_idx = IW'(i);
			end
		end
	end

	assign match_any  = |match_s1;
	assign free_any   = ~&active_q;
	assign start_ok   = match_any || free_any;
	assign sel_idx    = match_any ? match_idx : free_idx;
	assign match_idx5 = QCH_W'(match_idx);
	assign sel_idx5   = QCH_W'(sel_idx);
	assign scan_idx5  = QCH_W'(scan_idx_q);

	assign sts.scan_start = (act_q == ACT_STOPALL) && (|active_q);
	assign sts.is_start   = (act_q == ACT_START);
	assign sts.out_last   = last_q;
	assign sts.scan_hit   = active_q[scan_idx_q];

	always_comb begin
		dec_wv   = 1'b0;
		dec_ch   = '0;
		dec_val  = '0;
		dec_qch  = '0;
		dec_last = 1'b1;
		unique case (act_q)
			ACT_START: begin
				if (start_ok) begin
					dec_wv   = 1'b1;
					dec_ch   = sel_idx5[CH_W-1:0];
					dec_last = 1'b0;
				end
			end
			ACT_STOP: begin
				if (match_any) begin
					dec_wv  = 1'b1;
					dec_ch  = match_idx5[CH_W-1:0];
					dec_val = VAL_W'(1);
				end
			end
			ACT_STOPALL: begin
			end
			ACT_QUERY: begin
				dec_qch = match_any ? signed'(match_idx5) : '1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
		end else if (cmd.decide) begin
			if (act_q == ACT_START && start_ok) begin
				active_q[sel_idx] <= 1'b1;
			end else if (act_q == ACT_STOP && match_any) begin
				active_q[match_idx] <= 1'b0;
			end
		end else if (cmd.scan) begin
			active_q[scan_idx_q] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q    <= tsa_action_t'(action);
			tag_q    <= tag;
			pa_q     <= param_a;
			pb_q     <= param_b;
			match_s1 <= match_d;
		end

		if (cmd.decide) begin
			wv_q       <= dec_wv;
			ch_q       <= dec_ch;
			port_q     <= PORT_KEY;
			val_q      <= dec_val;
			qch_q      <= dec_qch;
			last_q     <= dec_last;
			beat_q     <= 1'b0;
			scan_idx_q <= '0;
			if (act_q == ACT_START && start_ok) begin
				slot_tag_q[sel_idx] <= tag_q;
			end
		end

		if (cmd.next_beat) begin
			beat_q <= 1'b1;
			if (!beat_q) begin
				port_q <= PORT_A;
				val_q  <= pa_q;
			end else begin
				port_q <= PORT_B;
				val_q  <= pb_q;
				last_q <= 1'b1;
			end
		end

		if (cmd.scan) begin
			scan_idx_q <= scan_idx_q + IW'(1);
			if (active_q[scan_idx_q]) begin
				wv_q   <= 1'b1;
				ch_q   <= scan_idx5[CH_W-1:0];
				port_q <= PORT_KEY;
				val_q  <= VAL_W'(1);
				qch_q  <= '0;
				last_q <= ~|rest_vec;
			end
		end
	end

	assign write_valid   = wv_q;
	assign channel       = ch_q;
	assign port_index    = port_q;
	assign write_value   = val_q;
	assign query_channel = qch_q;
	assign last          = last_q;

endmodule
`default_nettype wire

// ===== sv/tsa_checker.sv =====
`default_nettype none
module tsa_checker (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	input  wire logic                              in_ready,
	input  wire logic [1:0]                        action,
	input  wire logic [tsa_pkg::TAG_W-1:0]         tag,
	input  wire logic signed [tsa_pkg::VAL_W-1:0]  param_a,
	input  wire logic signed [tsa_pkg::VAL_W-1:0]  param_b,
	input  wire logic                              out_valid,
	input  wire logic                              out_ready,
	input  wire logic                              write_valid,
	input  wire logic [tsa_pkg::CH_W-1:0]          channel,
	input  wire logic [tsa_pkg::PORT_W-1:0]        port_index,
	input  wire logic signed [tsa_pkg::VAL_W-1:0]  write_value,
	input  wire logic signed [tsa_pkg::QCH_W-1:0]  query_channel,
	input  wire logic                              last
);
	import tsa_pkg::*;

	// The block works on one request at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input accepted while a result is pending");

	// After an input transaction the block is busy in the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (!in_ready && !out_valid))
		else $error("no decision cycle after input transaction");

	// A result without last means more results follow before new input.
	a_more_follow: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !last) |=> !in_ready)
		else $error("request closed before its final result");

	// A result without a write is always the only one of its request.
	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !write_valid) |-> last)
		else $error("empty result not marked last");

	// A stalled result holds its payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=>
		(out_valid && $stable(channel) && $stable(write_value) && $stable(last)))
		else $error("stalled result changed");

endmodule

bind tagged_slot_allocator tsa_checker u_tsa_checker (.*);
`default_nettype wire

// ===== bench/tb.sv =====
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import tsa_pkg::*;

	localparam int NSLOT        = SLOT_COUNT_DEF;
	localparam int IDLE_LIMIT   = 3000;
	localparam int DRAIN_CYCLES = 40;
	localparam int TAG_POOL     = 16;

	typedef struct packed {
		logic              wr;
		logic [CH_W-1:0]   ch;
		logic [PORT_W-1:0] port;
		logic [VAL_W-1:0]  value;
		logic [QCH_W-1:0]  qch;
		logic              is_last;
	} port_write_t;

	logic                    clk           = 1'b0;
	logic                    arst_n        = 1'b0;
	logic                    in_valid      = 1'b0;
	logic                    in_ready;
	logic [1:0]              action        = ACT_QUERY;
	logic [TAG_W-1:0]        tag           = '0;
	logic signed [VAL_W-1:0] param_a       = '0;
	logic signed [VAL_W-1:0] param_b       = '0;
	logic                    out_valid;
	logic                    out_ready     = 1'b0;
	logic                    write_valid;
	logic [CH_W-1:0]         channel;
	logic [PORT_W-1:0]       port_index;
	logic signed [VAL_W-1:0] write_value;
	logic signed [QCH_W-1:0] query_channel;
	logic                    last;

	tagged_slot_allocator #(.SLOT_COUNT(NSLOT)) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.tag          (tag),
		.param_a      (param_a),
		.param_b      (param_b),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.write_valid  (write_valid),
		.channel      (channel),
		.port_index   (port_index),
		.write_value  (write_value),
		.query_channel(query_channel),
		.last         (last)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Shadow copy of the slot table and the writes it predicts.
	logic             slot_busy [NSLOT];
	logic [TAG_W-1:0] slot_key  [NSLOT];
	port_write_t      expected_writes [$];
	logic [TAG_W-1:0] tag_pool [TAG_POOL];

	bit tx_gaps_on   = 1'b1;
	bit rx_stalls_on = 1'b1;
	int stall_left   = 0;
	int idle_cycles  = 0;
	int mismatches   = 0;
	int results_seen = 0;
	int full_starts  = 0;
	int req_count [4] = '{0, 0, 0, 0};

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic int lookup_slot(logic [TAG_W-1:0] key);
		for (int i = 0; i < NSLOT; i++)
			if (slot_busy[i] && slot_key[i] == key)
				return i;
		return -1;
	endfunction

	function automatic port_write_t make_write(logic wr, int ch, logic [PORT_W-1:0] port,
			logic [VAL_W-1:0] value, logic [QCH_W-1:0] qch, logic is_last);
		port_write_t w;
		w.wr      = wr;
		w.ch      = CH_W'(ch);
		w.port    = port;
		w.value   = value;
		w.qch     = qch;
		w.is_last = is_last;
		return w;
	endfunction

	function automatic void predict_request(tsa_action_t act, logic [TAG_W-1:0] key,
			logic [VAL_W-1:0] pa, logic [VAL_W-1:0] pb);
		int s;
		int n;
		port_write_t w;
		n = 0;
		s = lookup_slot(key);
		case (act)
		ACT_START: begin
			for (int i = NSLOT - 1; i >= 0; i--)
				if (s < 0 && !slot_busy[i])
					n = i + 1;
			if (s < 0)
				s = n - 1;
			if (s < 0) begin
				full_starts++;
				expected_writes.push_back(make_write(1'b0, 0, PORT_KEY, '0, '0, 1'b1));
			end else begin
				slot_key[s]  = key;
				slot_busy[s] = 1'b1;
				expected_writes.push_back(make_write(1'b1, s, PORT_KEY, '0, '0, 1'b0));
				expected_writes.push_back(make_write(1'b1, s, PORT_A, pa, '0, 1'b0));
				expected_writes.push_back(make_write(1'b1, s, PORT_B, pb, '0, 1'b1));
			end
		end
		ACT_STOP: begin
			if (s < 0) begin
				expected_writes.push_back(make_write(1'b0, 0, PORT_KEY, '0, '0, 1'b1));
			end else begin
				slot_busy[s] = 1'b0;
				expected_writes.push_back(make_write(1'b1, s, PORT_KEY, VAL_W'(1), '0, 1'b1));
			end
		end
		ACT_STOPALL: begin
			for (int i = 0; i < NSLOT; i++) begin
				if (slot_busy[i]) begin
					slot_busy[i] = 1'b0;
					expected_writes.push_back(make_write(1'b1, i, PORT_KEY, VAL_W'(1), '0, 1'b0));
					n++;
				end
			end
			if (n == 0) begin
				expected_writes.push_back(make_write(1'b0, 0, PORT_KEY, '0, '0, 1'b1));
			end else begin
				w = expected_writes.pop_back();
				w.is_last = 1'b1;
				expected_writes.push_back(w);
			end
		end
		default: begin
			expected_writes.push_back(make_write(1'b0, 0, PORT_KEY, '0,
				(s < 0) ? {QCH_W{1'b1}} : QCH_W'(s), 1'b1));
		end
		endcase
	endfunction

	// Presents one request and returns at the edge where it is accepted. A
	// back-to-back request keeps in_valid high across the boundary.
	task automatic send_request(tsa_action_t act, logic [TAG_W-1:0] key,
			logic [VAL_W-1:0] pa, logic [VAL_W-1:0] pb);
		int gap;
		gap = tx_gaps_on ? pick_gap() : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		action   <= act;
		tag      <= key;
		param_a  <= pa;
		param_b  <= pb;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		predict_request(act, key, pa, pb);
		req_count[act]++;
	endtask

	task automatic send_random_request();
		int r;
		tsa_action_t act;
		logic [TAG_W-1:0] key;
		r = $urandom_range(0, 99);
		if (r < 40)
			act = ACT_START;
		else if (r < 65)
			act = ACT_STOP;
		else if (r < 90)
			act = ACT_QUERY;
		else
			act = ACT_STOPALL;
		if ($urandom_range(0, 9) == 0)
			key = $urandom();
		else
			key = tag_pool[$urandom_range(0, TAG_POOL - 1)];
		send_request(act, key, VAL_W'($urandom_range(0, 255)), VAL_W'($urandom_range(0, 255)));
	endtask

	task automatic test_empty_table();
		send_request(ACT_QUERY, 32'h0000_0000, 8'h00, 8'h00);
		send_request(ACT_STOP, 32'hFFFF_FFFF, 8'h7F, 8'h80);
		send_request(ACT_STOPALL, 32'h0000_0000, 8'h00, 8'h00);
	endtask

	task automatic test_start_stop_reuse();
		send_request(ACT_START, 32'h0000_0000, 8'h80, 8'h7F);
		send_request(ACT_START, 32'hFFFF_FFFF, 8'h7F, 8'h80);
		send_request(ACT_QUERY, 32'hFFFF_FFFF, 8'h00, 8'h00);
		// Same tag again must land on the slot it already holds.
		send_request(ACT_START, 32'h0000_0000, 8'h00, 8'hFF);
		send_request(ACT_STOP, 32'h0000_0000, 8'h00, 8'h00);
		send_request(ACT_QUERY, 32'h0000_0000, 8'h00, 8'h00);
	endtask

	task automatic test_table_full();
		for (int i = 0; i < NSLOT - 1; i++)
			send_request(ACT_START, 32'hA5A5_0000 | i, VAL_W'(i), VAL_W'(-i));
		send_request(ACT_START, 32'h1234_5678, 8'h11, 8'h22);
		// A matching tag still gets its slot while the table is full.
		send_request(ACT_START, 32'hFFFF_FFFF, 8'h01, 8'hFE);
		send_request(ACT_STOPALL, 32'h0000_0000, 8'h00, 8'h00);
	endtask

	task automatic test_back_to_back();
		tx_gaps_on   = 1'b0;
		rx_stalls_on = 1'b0;
		repeat (60) send_random_request();
		tx_gaps_on   = 1'b1;
		rx_stalls_on = 1'b1;
	endtask

	task automatic test_random_traffic();
		repeat (225) send_random_request();
	endtask

	// Result checker and receiver stalls.
	always @(posedge clk) begin
		port_write_t got;
		port_write_t want;
		got = '{write_valid, channel, port_index, write_value, query_channel, last};
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (expected_writes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result with nothing expected: wr=%b ch=%0d port=%0d val=%0d q=%0d last=%b",
						$realtime, got.wr, got.ch, got.port, $signed(got.value),
						$signed(got.qch), got.is_last);
			end else begin
				want = expected_writes.pop_front();
				if (got.wr !== want.wr || got.ch !== want.ch || got.port !== want.port ||
						got.value !== want.value || got.qch !== want.qch ||
						got.is_last !== want.is_last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: expected wr=%b ch=%0d port=%0d val=%0d q=%0d last=%b, got wr=%b ch=%0d port=%0d val=%0d q=%0d last=%b",
							$realtime, want.wr, want.ch, want.port, $signed(want.value),
							$signed(want.qch), want.is_last, got.wr, got.ch, got.port,
							$signed(got.value), $signed(got.qch), got.is_last);
				end
			end
		end
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_ready  <= 1'b0;
		end else if (rx_stalls_on && $urandom_range(0, 3) == 0) begin
			stall_left <= pick_gap();
			out_ready  <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("No transaction for %0d cycles, giving up.", IDLE_LIMIT);
			$display("FAILED: results differ");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		foreach (slot_busy[i]) begin
			slot_busy[i] = 1'b0;
			slot_key[i]  = '0;
		end
		// Half the pool are near misses of the other half, one bit apart.
		for (int i = 0; i < TAG_POOL / 2; i++) begin
			tag_pool[i]                = $urandom();
			tag_pool[i + TAG_POOL / 2] = tag_pool[i] ^ (32'h1 << $urandom_range(0, TAG_W - 1));
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		test_empty_table();
		test_start_stop_reuse();
		test_table_full();
		test_back_to_back();
		test_random_traffic();

		in_valid <= 1'b0;
		while (expected_writes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d starts (%0d on a full table), %0d stops, %0d stop-alls, %0d queries.",
			req_count[ACT_START], full_starts, req_count[ACT_STOP],
			req_count[ACT_STOPALL], req_count[ACT_QUERY]);
		$display("Checked %0d results under random gaps and stalls, %0d mismatches.",
			results_seen, mismatches);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end
endmodule

// ===== filelist.f =====
sv/tsa_pkg.sv
sv/tsa_ctrl.sv
sv/tsa_datapath.sv
sv/tagged_slot_allocator.sv
sv/tsa_checker.sv
bench/tb.sv
